// ===== hdl/esk_pkg.sv =====
package esk_pkg;

  localparam int TABLE_ENTRIES = 512;
  localparam int MAX_SEQ_LEN   = 16;
  localparam int BUFFER_DEPTH  = 16;
  localparam int KEY_CODE_BITS = 10;

  localparam int ENTRY_W  = $clog2(TABLE_ENTRIES);
  localparam int POS_W    = $clog2(MAX_SEQ_LEN);
  localparam int BADDR_W  = ENTRY_W + POS_W;
  localparam int EP_W     = ENTRY_W + 1;
  localparam int FILL_W   = $clog2(BUFFER_DEPTH + 1);
  localparam int BIDX_W   = $clog2(BUFFER_DEPTH);
  localparam int COUNT_W  = 10;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 21;

  typedef enum logic [1:0] {
    FUNC_KEY      = 2'd0,
    FUNC_TIMEOUT  = 2'd1,
    FUNC_WR_BYTE  = 2'd2,
    FUNC_WR_CODE  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UTF8_MODE   = 2'd0,
    CFG_ENTRY_COUNT = 2'd1
  } cfg_idx_e;

  localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KEY     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;

  localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;

  typedef logic [BUFFER_DEPTH-1:0][7:0] buf_data_t;

  // Operations on the input buffer, at most one per cycle.
  typedef struct packed {
    logic push;
    logic shift;
    logic clear;
  } buf_ctl_t;

  // Total length of a multi-byte UTF-8 sequence from its first byte, 0 if the byte cannot lead one.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'hC0)      len = 3'd0;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else if (b < 8'hFE) len = 3'd6;
    else                len = 3'd0;
    return len;
  endfunction

endpackage

// ===== hdl/esk_ram.sv =====
module esk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/esk_buf.sv =====
module esk_buf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  esk_pkg::buf_ctl_t       ctl_i,
  input  logic [7:0]              push_byte_i,
  output esk_pkg::buf_data_t      data_o,
  output logic [esk_pkg::FILL_W-1:0] fill_o
);
  import esk_pkg::*;

  buf_data_t         data_q;
  logic [FILL_W-1:0] fill_q;

  // Bytes move toward the front one place per shift.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      data_q[fill_q[BIDX_W-1:0]] <= push_byte_i;
    end else if (ctl_i.shift) begin
      for (int i = 0; i < BUFFER_DEPTH - 1; i++) begin
        data_q[i] <= data_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctl_i.clear) begin
      fill_q <= '0;
    end else if (ctl_i.push) begin
      fill_q <= fill_q + FILL_W'(1);
    end else if (ctl_i.shift) begin
      fill_q <= fill_q - FILL_W'(1);
    end
  end

  assign data_o = data_q;
  assign fill_o = fill_q;

endmodule

// ===== hdl/esk_ctrl.sv =====
module esk_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          utf8_mode_i,
  input  logic [esk_pkg::COUNT_W-1:0]   count_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  esk_pkg::buf_data_t            buf_data_i,
  input  logic [esk_pkg::FILL_W-1:0]    fill_i,
  output esk_pkg::buf_ctl_t             buf_ctl_o,
  output logic                          byte_we_o,
  output logic                          code_we_o,
  output logic [esk_pkg::BADDR_W-1:0]   byte_raddr_o,
  output logic [esk_pkg::ENTRY_W-1:0]   code_raddr_o,
  input  logic [7:0]                    byte_rdata_i,
  input  logic [esk_pkg::KEY_CODE_BITS-1:0] code_rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [esk_pkg::KIND_W-1:0]    kind_o,
  output logic [esk_pkg::VALUE_W-1:0]   value_o,
  output logic                          last_o
);
  import esk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TB, S_TB1, S_CODE, S_PUSH, S_DROP, S_DONE
  } state_e;

  state_e              state_q;
  logic [FILL_W-1:0]   ml_q;
  logic [EP_W-1:0]     ep_q;
  logic                partial_q;
  logic [FILL_W-1:0]   res_cnt_q;
  logic [FILL_W-1:0]   drop_q;
  logic                pend_valid_q;
  logic [KIND_W-1:0]   pend_kind_q;
  logic [VALUE_W-1:0]  pend_val_q;
  logic [KIND_W-1:0]   new_kind_q;
  logic [VALUE_W-1:0]  new_val_q;
  logic                out_valid_q;
  logic [KIND_W-1:0]   out_kind_q;
  logic [VALUE_W-1:0]  out_val_q;
  logic                out_last_q;

  logic                accept;
  logic                out_free;
  logic [7:0]          cur_byte;
  logic [7:0]          first_byte;
  logic [FILL_W-1:0]   ml_inc;
  logic [31:0]         utf8_val;
  logic [VALUE_W-1:0]  key_val;

  function automatic logic [31:0] utf8_decode(input buf_data_t d, input logic [FILL_W-1:0] len);
    logic [31:0] v;
    v = {24'd0, d[0] & (8'h7F >> len)};
    for (int i = 1; i < 6; i++) begin
      if (FILL_W'(i) < len) begin
        v = {v[25:0], d[i][5:0]};
      end
    end
    return v;
  endfunction

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cur_byte   = buf_data_i[ml_q[BIDX_W-1:0]];
  assign first_byte = buf_data_i[0];
  assign ml_inc     = ml_q + FILL_W'(1);
  assign utf8_val   = utf8_decode(buf_data_i, ml_inc);
  assign key_val    = VALUE_W'(code_rdata_i);

  always_comb begin
    buf_ctl_o.push  = accept && (func_i == FUNC_KEY) && (fill_i < FILL_W'(BUFFER_DEPTH));
    buf_ctl_o.clear = accept && (func_i == FUNC_TIMEOUT) && (fill_i != '0) && partial_q;
    buf_ctl_o.shift = (state_q == S_DROP) && (drop_q != '0) && (fill_i != '0);
    byte_we_o       = accept && (func_i == FUNC_WR_BYTE);
    code_we_o       = accept && (func_i == FUNC_WR_CODE);
    if (state_q == S_TB) begin
      byte_raddr_o = {ep_q[ENTRY_W-1:0], ml_inc[POS_W-1:0]};
    end else begin
      byte_raddr_o = {ep_q[ENTRY_W-1:0], ml_q[POS_W-1:0]};
    end
    code_raddr_o = ep_q[ENTRY_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ml_q         <= '0;
      ep_q         <= '0;
      partial_q    <= 1'b0;
      res_cnt_q    <= '0;
      drop_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_kind_q  <= KIND_CHAR;
      pend_val_q   <= '0;
      new_kind_q   <= KIND_CHAR;
      new_val_q    <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_CHAR;
      out_val_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (func_i == FUNC_KEY) begin
              if (fill_i < FILL_W'(BUFFER_DEPTH)) begin
                res_cnt_q <= '0;
                state_q   <= S_SCAN;
              end
            end else if (func_i == FUNC_TIMEOUT && fill_i != '0) begin
              ml_q      <= '0;
              partial_q <= 1'b0;
              if (!partial_q) begin
                pend_kind_q  <= KIND_CHAR;
                pend_val_q   <= VALUE_W'(first_byte);
                pend_valid_q <= 1'b1;
                res_cnt_q    <= FILL_W'(1);
                drop_q       <= FILL_W'(1);
                ep_q         <= '0;
                state_q      <= S_DROP;
              end
            end
          end
        end
        S_SCAN: begin
          if (res_cnt_q == FILL_W'(BUFFER_DEPTH) || ml_q >= fill_i) begin
            state_q <= S_DONE;
          end else if (ml_q == '0 && utf8_mode_i && first_byte[7]) begin
            partial_q <= 1'b1;
            ml_q      <= FILL_W'(1);
          end else if (partial_q) begin
            if (cur_byte[7:6] == 2'b10) begin
              if (FILL_W'(lead_length(first_byte)) == ml_inc) begin
                if (utf8_val > MAX_CODE_POINT) begin
                  new_kind_q <= KIND_INVALID;
                  new_val_q  <= '0;
                end else begin
                  new_kind_q <= KIND_CHAR;
                  new_val_q  <= utf8_val[VALUE_W-1:0];
                end
                drop_q    <= ml_inc;
                res_cnt_q <= res_cnt_q + FILL_W'(1);
                ml_q      <= '0;
                ep_q      <= '0;
                partial_q <= 1'b0;
                state_q   <= S_PUSH;
              end else begin
                ml_q <= ml_inc;
              end
            end else begin
              // Bad continuation: the lead byte goes, nothing is reported.
              drop_q    <= FILL_W'(1);
              partial_q <= 1'b0;
              ml_q      <= '0;
              state_q   <= S_DROP;
            end
          end else if (ep_q >= EP_W'(count_i)) begin
            new_kind_q <= KIND_CHAR;
            new_val_q  <= VALUE_W'(first_byte);
            drop_q     <= FILL_W'(1);
            res_cnt_q  <= res_cnt_q + FILL_W'(1);
            ml_q       <= '0;
            ep_q       <= '0;
            state_q    <= S_PUSH;
          end else begin
            state_q <= S_TB;
          end
        end
        S_TB: begin
          if (byte_rdata_i != '0 && byte_rdata_i == cur_byte) begin
            if (ml_q == FILL_W'(MAX_SEQ_LEN - 1)) begin
              state_q <= S_CODE;
            end else begin
              state_q <= S_TB1;
            end
          end else if (cur_byte > byte_rdata_i) begin
            new_kind_q <= KIND_CHAR;
            new_val_q  <= VALUE_W'(first_byte);
            drop_q     <= FILL_W'(1);
            res_cnt_q  <= res_cnt_q + FILL_W'(1);
            ml_q       <= '0;
            ep_q       <= '0;
            state_q    <= S_PUSH;
          end else begin
            ml_q    <= '0;
            ep_q    <= ep_q + EP_W'(1);
            state_q <= S_SCAN;
          end
        end
        S_TB1, S_CODE: begin
          if (state_q == S_CODE || byte_rdata_i == '0) begin
            new_kind_q <= KIND_KEY;
            new_val_q  <= key_val;
            drop_q     <= ml_inc;
            res_cnt_q  <= res_cnt_q + FILL_W'(1);
            ml_q       <= '0;
            ep_q       <= '0;
            state_q    <= S_PUSH;
          end else begin
            ml_q    <= ml_inc;
            state_q <= S_SCAN;
          end
        end
        S_PUSH: begin
          // The previous result leaves with last clear once a newer one exists.
          if (!pend_valid_q) begin
            pend_kind_q  <= new_kind_q;
            pend_val_q   <= new_val_q;
            pend_valid_q <= 1'b1;
            state_q      <= S_DROP;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= pend_kind_q;
            out_val_q   <= pend_val_q;
            out_last_q  <= 1'b0;
            pend_kind_q <= new_kind_q;
            pend_val_q  <= new_val_q;
            state_q     <= S_DROP;
          end
        end
        S_DROP: begin
          if (drop_q == '0 || fill_i == '0) begin
            state_q <= S_SCAN;
          end else begin
            drop_q <= drop_q - FILL_W'(1);
          end
        end
        S_DONE: begin
          if (!pend_valid_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= pend_kind_q;
            out_val_q    <= pend_val_q;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign value_o     = out_val_q;
  assign last_o      = out_last_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("result still pending while idle");

  a_entry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ep_q <= EP_W'(TABLE_ENTRIES))
    else $error("entry pointer beyond table");

  a_result_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= FILL_W'(BUFFER_DEPTH))
    else $error("too many results for one request");

  a_lookahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TB1) |-> (ml_q < FILL_W'(MAX_SEQ_LEN - 1)))
    else $error("lookahead read past sequence end");

endmodule

// ===== hdl/escape_sequence_key_matcher_top.sv =====
// Escape-sequence key matcher. Each request carries a function code: a keyboard byte is
// buffered (up to 16 bytes; a byte arriving on a full buffer is dropped) and matched against
// a table of up to 512 key sequences held in on-chip RAM, which must be sorted in descending
// byte order; a timeout flushes the first buffered byte as a plain character and matches the
// rest, or clears the whole buffer while a UTF-8 sequence is incomplete; the two write
// functions load sequence bytes and key codes into the table. A request produces zero to
// sixteen results, the final one marked with last. Throughput is set by the single read port
// of the sequence byte RAM, which the walk uses one address per cycle while it compares: a
// table entry that fails on its compared byte costs a read and a compare, and every byte that
// matches costs a read, a compare and a lookahead read. A result is then handed over and its
// bytes shifted out of the buffer one place per shift. A keyboard byte or a flushing timeout
// holds the input stalled until the request ends, also through any output stall. Table writes
// and ignored requests complete without leaving idle. The table RAMs power up undefined and
// need no clearing; only entries that were written may be matched. The user must write
// configuration (utf8_mode, entry_count) only while no request is in flight; the block does not enforce this.
module escape_sequence_key_matcher_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [esk_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [esk_pkg::COUNT_W-1:0]      cfg_data_i,
  // Request channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       func_i,
  input  logic [esk_pkg::ENTRY_W-1:0]      entry_i,
  input  logic [esk_pkg::POS_W-1:0]        position_i,
  input  logic [7:0]                       data_byte_i,
  input  logic [9:0]                       key_value_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [esk_pkg::KIND_W-1:0]       kind_o,
  output logic [esk_pkg::VALUE_W-1:0]      value_o,
  output logic                             last_o
);
  import esk_pkg::*;

  logic               utf8_mode_q;
  logic [COUNT_W-1:0] entry_count_q;
  logic [COUNT_W-1:0] count;

  buf_data_t          buf_data;
  logic [FILL_W-1:0]  fill;
  buf_ctl_t           buf_ctl;

  logic                     byte_we;
  logic                     code_we;
  logic [BADDR_W-1:0]       byte_raddr;
  logic [ENTRY_W-1:0]       code_raddr;
  logic [7:0]               byte_rdata;
  logic [KEY_CODE_BITS-1:0] code_rdata;

  // Register writes to an index outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utf8_mode_q   <= 1'b0;
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_UTF8_MODE:   utf8_mode_q   <= cfg_data_i[0];
        CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // An entry count larger than the table acts as the full table.
  assign count = (entry_count_q > COUNT_W'(TABLE_ENTRIES)) ? COUNT_W'(TABLE_ENTRIES)
                                                            : entry_count_q;

  // Sequence bytes: entry-major, one row of sixteen bytes per entry.
  esk_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_ENTRIES * MAX_SEQ_LEN)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i ({entry_i, position_i}),
    .wdata_i (data_byte_i),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  // Key codes, one per entry.
  esk_ram #(
    .WIDTH (KEY_CODE_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (entry_i),
    .wdata_i (key_value_i[KEY_CODE_BITS-1:0]),
    .raddr_i (code_raddr),
    .rdata_o (code_rdata)
  );

  esk_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (buf_ctl),
    .push_byte_i (data_byte_i),
    .data_o      (buf_data),
    .fill_o      (fill)
  );

  esk_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .utf8_mode_i  (utf8_mode_q),
    .count_i      (count),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .buf_data_i   (buf_data),
    .fill_i       (fill),
    .buf_ctl_o    (buf_ctl),
    .byte_we_o    (byte_we),
    .code_we_o    (code_we),
    .byte_raddr_o (byte_raddr),
    .code_raddr_o (code_raddr),
    .byte_rdata_i (byte_rdata),
    .code_rdata_i (code_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

endmodule
